/* sv/nmea_pkg.sv */
// ============================================================================
// NMEA position parser package
// Shared types, character codes, sentence kind codes and constant tables.
// ============================================================================
package nmea_pkg;

    localparam int WHOLE_W = 17;
    localparam int FRAC_W  = 20;
    localparam int CNT_W   = 3;
    localparam int FIELD_W = 5;
    localparam int MAG_W   = 31;
    localparam int DEG_W   = 11;

    localparam logic [WHOLE_W-1:0] WHOLE_MAX  = 17'd131071;
    localparam logic [MAG_W-1:0]   COORD_MAX  = 31'd1800000000;
    localparam longint             E7         = 64'd10000000;
    localparam longint             DIV100_MUL = 64'd167773;
    localparam int                 DIV100_SHIFT = 24;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_GGA  = 3'd0;
    localparam t_kind KIND_RMC  = 3'd1;
    localparam t_kind KIND_GSA  = 3'd2;
    localparam t_kind KIND_GSV  = 3'd3;
    localparam t_kind KIND_VTG  = 3'd4;
    localparam t_kind KIND_GLL  = 3'd5;
    localparam t_kind KIND_NONE = 3'd7;

    typedef struct packed {
        logic               has;
        logic [FIELD_W-1:0] base;
    } t_pos;

    typedef struct packed {
        logic  conv;
        logic  conv_lon;
        logic  coord_ok;
        logic  emit;
        t_kind kind;
        logic  lat_neg;
        logic  lon_neg;
    } t_ctrl;

    typedef struct packed {
        t_ctrl              ctrl;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
    } t_token;

    typedef struct packed {
        t_kind            kind;
        logic [MAG_W-1:0] lat_mag;
        logic             lat_ok;
        logic             lat_neg;
        logic [MAG_W-1:0] lon_mag;
        logic             lon_ok;
        logic             lon_neg;
    } t_result;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] lat;
        logic               lat_ok;
        logic signed [31:0] lon;
        logic               lon_ok;
    } t_beat;

    function automatic t_kind kind_of(input logic [23:0] tag, input logic [1:0] len);
        t_kind k;
        k = KIND_NONE;
        if (len == 2'd3) begin
            if (tag == {8'h47, 8'h47, 8'h41}) k = KIND_GGA;
            else if (tag == {8'h52, 8'h4D, 8'h43}) k = KIND_RMC;
            else if (tag == {8'h47, 8'h53, 8'h41}) k = KIND_GSA;
            else if (tag == {8'h47, 8'h53, 8'h56}) k = KIND_GSV;
            else if (tag == {8'h56, 8'h54, 8'h47}) k = KIND_VTG;
            else if (tag == {8'h47, 8'h4C, 8'h4C}) k = KIND_GLL;
        end
        return k;
    endfunction

    function automatic t_pos pos_of(input t_kind k);
        t_pos p;
        p = '0;
        unique case (k)
            KIND_GGA: p = '{has: 1'b1, base: 5'd2};
            KIND_RMC: p = '{has: 1'b1, base: 5'd3};
            KIND_GLL: p = '{has: 1'b1, base: 5'd1};
            default:  p = '0;
        endcase
        return p;
    endfunction

    function automatic logic [FRAC_W-1:0] pow10_frac(input logic [CNT_W-1:0] e);
        logic [FRAC_W-1:0] v;
        unique case (e)
            3'd0:    v = 20'd1;
            3'd1:    v = 20'd10;
            3'd2:    v = 20'd100;
            3'd3:    v = 20'd1000;
            3'd4:    v = 20'd10000;
            3'd5:    v = 20'd100000;
            3'd6:    v = 20'd1000000;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    // Minutes scale 1e7 / (60 * 10^n) reduced to a numerator and a denominator.
    function automatic longint coef_a(input int n);
        longint a;
        unique case (n)
            1:       a = 64'd50000;
            2:       a = 64'd5000;
            3:       a = 64'd500;
            4:       a = 64'd50;
            5:       a = 64'd5;
            default: a = 64'd1;
        endcase
        return a;
    endfunction

    function automatic longint coef_b(input int n);
        longint b;
        unique case (n)
            6:       b = 64'd6;
            default: b = 64'd3;
        endcase
        return b;
    endfunction

endpackage

/* sv/nmea_byte_parser.sv */
// ============================================================================
// NMEA byte parser
// Tracks line, field and tag state per received byte and issues a token for
// each coordinate field end and each end of a sentence of a known kind.
// ============================================================================
module nmea_byte_parser
    import nmea_pkg::*;
#(
    parameter int MINUTE_FRACTION_DIGITS = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_tok_valid,
    output t_token     o_tok
);

    localparam logic [CNT_W-1:0] FRAC_N   = CNT_W'(MINUTE_FRACTION_DIGITS);
    localparam logic [CNT_W-1:0] FRAC_TOP = CNT_W'(MINUTE_FRACTION_DIGITS - 1);

    logic               r_in_sentence, n_in_sentence;
    logic               r_line_started, n_line_started;
    logic [FIELD_W-1:0] r_field_num, n_field_num;
    logic [23:0]        r_tag, n_tag;
    logic [1:0]         r_tag_len, n_tag_len;
    logic               r_star, n_star;
    logic [WHOLE_W-1:0] r_whole, n_whole;
    logic [1:0]         r_dbp, n_dbp;
    logic               r_point, n_point;
    logic [FRAC_W-1:0]  r_frac, n_frac;
    logic [CNT_W-1:0]   r_frac_cnt, n_frac_cnt;
    logic               r_malformed, n_malformed;
    logic [1:0]         r_hemi_cnt, n_hemi_cnt;
    logic               r_hemi_neg, n_hemi_neg;
    logic               r_lat_neg, n_lat_neg;
    logic               r_lon_neg, n_lon_neg;
    logic               r_tok_valid, n_tok_valid;
    t_token             r_tok, n_tok;

    logic               acc;
    logic               fin;
    logic               clr_field;
    logic               clr_line;
    logic               is_digit;
    logic [3:0]         digit;
    logic [20:0]        whole_ext;
    t_kind              kind;
    t_pos               pos;
    logic               hemi_now;

    assign acc = i_valid && i_advance;

    always_comb begin
        n_in_sentence  = r_in_sentence;
        n_line_started = r_line_started;
        n_field_num    = r_field_num;
        n_tag          = r_tag;
        n_tag_len      = r_tag_len;
        n_star         = r_star;
        n_whole        = r_whole;
        n_dbp          = r_dbp;
        n_point        = r_point;
        n_frac         = r_frac;
        n_frac_cnt     = r_frac_cnt;
        n_malformed    = r_malformed;
        n_hemi_cnt     = r_hemi_cnt;
        n_hemi_neg     = r_hemi_neg;
        n_lat_neg      = r_lat_neg;
        n_lon_neg      = r_lon_neg;
        n_tok          = '0;
        n_tok_valid    = 1'b0;
        fin            = 1'b0;
        clr_field      = 1'b0;
        clr_line       = 1'b0;

        kind      = kind_of(r_tag, r_tag_len);
        pos       = pos_of(kind);
        is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        digit     = 4'(i_byte - CH_ZERO);
        whole_ext = 21'(r_whole) * 21'd10 + 21'(digit);
        hemi_now  = (r_hemi_cnt == 2'd1) && r_hemi_neg;

        if (acc) begin
            priority if (i_byte == CH_CR) begin
            end else if (i_byte == CH_LF) begin
                fin            = r_in_sentence;
                n_tok.ctrl.emit = r_in_sentence && (kind != KIND_NONE);
                n_in_sentence  = 1'b0;
                n_line_started = 1'b0;
                clr_line       = 1'b1;
            end else if (!r_line_started) begin
                n_line_started = 1'b1;
                clr_line       = 1'b1;
                n_in_sentence  = (i_byte == CH_DOLLAR);
            end else if (!r_in_sentence) begin
            end else if (i_byte == CH_COMMA) begin
                fin       = 1'b1;
                clr_field = 1'b1;
                if (r_field_num != '1) begin
                    n_field_num = r_field_num + 1'b1;
                end
            end else if (r_field_num == '0) begin
                if (!r_star) begin
                    if (i_byte == CH_STAR) begin
                        n_star = 1'b1;
                    end else begin
                        n_tag = {r_tag[15:0], i_byte};
                        if (r_tag_len != 2'd3) begin
                            n_tag_len = r_tag_len + 1'b1;
                        end
                    end
                end
            end else begin
                if (r_hemi_cnt == 2'd0) begin
                    n_hemi_neg = (i_byte == CH_S) || (i_byte == CH_W);
                end
                if (r_hemi_cnt != 2'd2) begin
                    n_hemi_cnt = r_hemi_cnt + 1'b1;
                end
                priority if (is_digit) begin
                    if (!r_point) begin
                        n_whole = (whole_ext > 21'(WHOLE_MAX)) ? WHOLE_MAX : whole_ext[16:0];
                        if (r_dbp != 2'd2) begin
                            n_dbp = r_dbp + 1'b1;
                        end
                    end else if (r_frac_cnt < FRAC_N) begin
                        n_frac = r_frac +
                                 FRAC_W'(FRAC_W'(digit) * pow10_frac(FRAC_TOP - r_frac_cnt));
                        n_frac_cnt = r_frac_cnt + 1'b1;
                    end
                end else if (i_byte == CH_POINT) begin
                    if (r_point || (r_dbp != 2'd2)) begin
                        n_malformed = 1'b1;
                    end
                    n_point = 1'b1;
                end else begin
                    n_malformed = 1'b1;
                end
            end
        end

        if (fin && pos.has) begin
            if (r_field_num == pos.base) begin
                n_tok.ctrl.conv = 1'b1;
            end else if (r_field_num == pos.base + 5'd1) begin
                n_lat_neg = hemi_now;
            end else if (r_field_num == pos.base + 5'd2) begin
                n_tok.ctrl.conv     = 1'b1;
                n_tok.ctrl.conv_lon = 1'b1;
            end else if (r_field_num == pos.base + 5'd3) begin
                n_lon_neg = hemi_now;
            end
        end

        n_tok.ctrl.coord_ok = r_point && !r_malformed;
        n_tok.ctrl.kind     = kind;
        n_tok.ctrl.lat_neg  = n_lat_neg;
        n_tok.ctrl.lon_neg  = n_lon_neg;
        n_tok.whole         = r_whole;
        n_tok.frac          = r_frac;
        n_tok_valid         = n_tok.ctrl.conv || n_tok.ctrl.emit;

        if (clr_field || clr_line) begin
            n_whole     = '0;
            n_dbp       = '0;
            n_point     = 1'b0;
            n_frac      = '0;
            n_frac_cnt  = '0;
            n_malformed = 1'b0;
            n_hemi_cnt  = '0;
            n_hemi_neg  = 1'b0;
        end
        if (clr_line) begin
            n_field_num = '0;
            n_tag       = '0;
            n_tag_len   = '0;
            n_star      = 1'b0;
            n_lat_neg   = 1'b0;
            n_lon_neg   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence  <= 1'b0;
            r_line_started <= 1'b0;
            r_field_num    <= '0;
            r_tag          <= '0;
            r_tag_len      <= '0;
            r_star         <= 1'b0;
            r_whole        <= '0;
            r_dbp          <= '0;
            r_point        <= 1'b0;
            r_frac         <= '0;
            r_frac_cnt     <= '0;
            r_malformed    <= 1'b0;
            r_hemi_cnt     <= '0;
            r_hemi_neg     <= 1'b0;
            r_lat_neg      <= 1'b0;
            r_lon_neg      <= 1'b0;
            r_tok_valid    <= 1'b0;
        end else if (i_advance) begin
            r_in_sentence  <= n_in_sentence;
            r_line_started <= n_line_started;
            r_field_num    <= n_field_num;
            r_tag          <= n_tag;
            r_tag_len      <= n_tag_len;
            r_star         <= n_star;
            r_whole        <= n_whole;
            r_dbp          <= n_dbp;
            r_point        <= n_point;
            r_frac         <= n_frac;
            r_frac_cnt     <= n_frac_cnt;
            r_malformed    <= n_malformed;
            r_hemi_cnt     <= n_hemi_cnt;
            r_hemi_neg     <= n_hemi_neg;
            r_lat_neg      <= n_lat_neg;
            r_lon_neg      <= n_lon_neg;
            r_tok_valid    <= n_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

    a_sentence_needs_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_sentence |-> r_line_started)
        else $error("sentence flag set outside a started line");

    a_emit_known_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tok_valid && r_tok.ctrl.emit) |-> (r_tok.ctrl.kind != KIND_NONE))
        else $error("sentence end token without a known kind");

endmodule

/* sv/nmea_coord_convert.sv */
// ============================================================================
// NMEA coordinate converter
// Pipelined ddmm.mmmm to 1e-7 degree conversion, coordinate stores and the
// per-sentence result register.
// ============================================================================
module nmea_coord_convert
    import nmea_pkg::*;
#(
    parameter int MINUTE_FRACTION_DIGITS = 5
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  logic    i_tok_valid,
    input  t_token  i_tok,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam longint P10    = 64'(10 ** MINUTE_FRACTION_DIGITS);
    localparam longint COEF_A = coef_a(MINUTE_FRACTION_DIGITS);
    localparam longint COEF_B = coef_b(MINUTE_FRACTION_DIGITS);
    localparam longint DEN    = 2 * COEF_B;
    localparam longint M_MAX  = 100 * P10 - 1;
    localparam int     MW     = $clog2(M_MAX + 1);
    localparam longint X_MAX  = 2 * M_MAX * COEF_A + COEF_B;
    localparam int     XW     = $clog2(X_MAX + 1);
    localparam int     K      = XW + 4;
    localparam longint RECIP  = ((64'd1 << K) + DEN - 1) / DEN;
    localparam int     RW     = $clog2(RECIP + 1);
    localparam int     PW     = XW + RW;
    localparam int     DW     = 35;
    localparam int     P1W    = WHOLE_W + 18;

    logic               r1_valid;
    t_token             r1_tok;
    logic [P1W-1:0]     r1_prod;

    logic               r2_valid;
    t_ctrl              r2_ctrl;
    logic [DEG_W-1:0]   r2_deg;
    logic [MW-1:0]      r2_m;

    logic               r3_valid;
    t_ctrl              r3_ctrl;
    logic [DW-1:0]      r3_deg_e7;
    logic [XW-1:0]      r3_x;

    logic               r4_valid;
    t_ctrl              r4_ctrl;
    logic [DW-1:0]      r4_deg_e7;
    logic [PW-1:0]      r4_prod;

    logic [MAG_W-1:0]   r_lat_store, n_lat_store;
    logic               r_lat_ok, n_lat_ok;
    logic [MAG_W-1:0]   r_lon_store, n_lon_store;
    logic               r_lon_ok, n_lon_ok;
    logic               r_res_valid, n_res_valid;
    t_result            r_res, n_res;

    logic [DEG_W-1:0]   quot;
    logic [WHOLE_W-1:0] rem_full;
    logic [6:0]         rem;
    logic [PW-K-1:0]    mins;
    logic [DW-1:0]      total;
    logic [MAG_W-1:0]   value;
    logic [MAG_W-1:0]   lat_now;
    logic [MAG_W-1:0]   lon_now;
    logic               lat_ok_now;
    logic               lon_ok_now;

    assign quot     = r1_prod[DIV100_SHIFT +: DEG_W];
    assign rem_full = r1_tok.whole - WHOLE_W'(WHOLE_W'(quot) * 17'd100);
    assign rem      = rem_full[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_advance) begin
            r1_valid <= i_tok_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r1_tok    <= i_tok;
            r1_prod   <= P1W'(i_tok.whole) * P1W'(DIV100_MUL);
            r2_ctrl   <= r1_tok.ctrl;
            r2_deg    <= quot;
            r2_m      <= MW'(rem) * MW'(P10) + MW'(r1_tok.frac);
            r3_ctrl   <= r2_ctrl;
            r3_deg_e7 <= DW'(r2_deg) * DW'(E7);
            r3_x      <= XW'(r2_m) * XW'(2 * COEF_A) + XW'(COEF_B);
            r4_ctrl   <= r3_ctrl;
            r4_deg_e7 <= r3_deg_e7;
            r4_prod   <= PW'(r3_x) * PW'(RECIP);
        end
    end

    assign mins  = r4_prod[PW-1:K];
    assign total = r4_deg_e7 + DW'(mins);

    always_comb begin
        value = '0;
        if (r4_ctrl.coord_ok) begin
            value = (total > DW'(COORD_MAX)) ? COORD_MAX : total[MAG_W-1:0];
        end
        lat_now    = r_lat_store;
        lat_ok_now = r_lat_ok;
        lon_now    = r_lon_store;
        lon_ok_now = r_lon_ok;
        if (r4_ctrl.conv && !r4_ctrl.conv_lon) begin
            lat_now    = value;
            lat_ok_now = r4_ctrl.coord_ok;
        end
        if (r4_ctrl.conv && r4_ctrl.conv_lon) begin
            lon_now    = value;
            lon_ok_now = r4_ctrl.coord_ok;
        end

        n_res = '{kind: r4_ctrl.kind, lat_mag: lat_now, lat_ok: lat_ok_now,
                  lat_neg: r4_ctrl.lat_neg, lon_mag: lon_now, lon_ok: lon_ok_now,
                  lon_neg: r4_ctrl.lon_neg};
        n_res_valid = r4_valid && r4_ctrl.emit;

        n_lat_store = r_lat_store;
        n_lat_ok    = r_lat_ok;
        n_lon_store = r_lon_store;
        n_lon_ok    = r_lon_ok;
        if (r4_valid) begin
            if (r4_ctrl.emit) begin
                n_lat_store = '0;
                n_lat_ok    = 1'b0;
                n_lon_store = '0;
                n_lon_ok    = 1'b0;
            end else begin
                n_lat_store = lat_now;
                n_lat_ok    = lat_ok_now;
                n_lon_store = lon_now;
                n_lon_ok    = lon_ok_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_store <= '0;
            r_lat_ok    <= 1'b0;
            r_lon_store <= '0;
            r_lon_ok    <= 1'b0;
            r_res_valid <= 1'b0;
        end else if (i_advance) begin
            r_lat_store <= n_lat_store;
            r_lat_ok    <= n_lat_ok;
            r_lon_store <= n_lon_store;
            r_lon_ok    <= n_lon_ok;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lat_store <= COORD_MAX) && (r_lon_store <= COORD_MAX))
        else $error("coordinate store above saturation limit");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_lat_ok |-> (r_lat_store == '0)))
        else $error("latitude store nonzero without a valid decode");

endmodule

/* sv/nmea_out_buffer.sv */
// ============================================================================
// NMEA output buffer
// Applies hemisphere signs and holds result beats in an output register with
// a skid register, which also stalls the pipeline when full.
// ============================================================================
module nmea_out_buffer
    import nmea_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_advance,
    output logic    o_valid,
    output t_beat   o_beat
);

    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    t_beat              r_out, n_out;
    t_beat              r_skid, n_skid;
    t_beat              beat;
    logic               take;
    logic               push;
    logic signed [31:0] lat_abs;
    logic signed [31:0] lon_abs;

    assign o_advance = !r_skid_valid;
    assign take      = r_out_valid && i_ready;
    assign push      = i_res_valid && !r_skid_valid;
    assign lat_abs   = 32'({1'b0, i_res.lat_mag});
    assign lon_abs   = 32'({1'b0, i_res.lon_mag});

    always_comb begin
        beat.kind   = i_res.kind;
        beat.lat    = i_res.lat_neg ? -lat_abs : lat_abs;
        beat.lat_ok = i_res.lat_ok;
        beat.lon    = i_res.lon_neg ? -lon_abs : lon_abs;
        beat.lon_ok = i_res.lon_ok;

        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        priority if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                n_out       = beat;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = beat;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while the output register is empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready && i_res_valid))
        else $error("skid register filled without a stalled output");

endmodule

/* sv/nmea_position_sentence_parser.sv */
// ============================================================================
// NMEA position sentence parser
// Throughput: one byte beat per cycle by the single-pass parser unless stalled.
// A result beat is formed at the line feed beat that ends its sentence and passes
// through the parser token register, the four conversion stages, the result
// register and the output register.
// A full skid register stalls the whole pipeline until the output drains.
// Reset is synchronous and active low; it clears all line and field state.
// ============================================================================
module nmea_position_sentence_parser
    import nmea_pkg::*;
#(
    parameter int MINUTE_FRACTION_DIGITS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] latitude, [32] latitude_valid,
                                        // [64:33] longitude, [65] longitude_valid
    output logic [2:0]  m_axis_tuser    // [2:0] sentence_kind
);

    logic    advance;
    logic    tok_valid;
    t_token  tok;
    logic    res_valid;
    t_result res;
    t_beat   beat;

    nmea_byte_parser #(
        .MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .o_tok_valid (tok_valid),
        .o_tok       (tok)
    );

    nmea_coord_convert #(
        .MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)
    ) u_convert (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    nmea_out_buffer u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (m_axis_tready),
        .o_advance   (advance),
        .o_valid     (m_axis_tvalid),
        .o_beat      (beat)
    );

    assign s_axis_tready = advance;
    assign m_axis_tdata  = {6'b0, beat.lon_ok, beat.lon, beat.lat_ok, beat.lat};
    assign m_axis_tuser  = beat.kind;

endmodule
